[hdl/sia_pkg.sv]
// Shared types and constants of the sparse integer array store.
// No dependencies; sia_scan, the top level and the bench import this package.
`timescale 1ns / 1ps

package sia_pkg;

    // Action codes of a request
    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_ADD   = 3'd2;
    localparam logic [2:0] ACT_PREINC = 3'd3;
    localparam logic [2:0] ACT_POSTINC = 3'd4;

    // Status codes of a response
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // One table entry as held in the RAM
    typedef struct packed {
        logic        used;
        logic [31:0] index;
        logic [31:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Result flags of one scan over the table
    typedef struct packed {
        logic hit;
        logic free;
    } scan_flags_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

endpackage

[hdl/sia_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing but the standard language.
`timescale 1ns / 1ps

interface sia_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] index;
    logic signed [31:0] operand;

    modport source (output valid, action, index, operand, input ready);
    modport sink (input valid, action, index, operand, output ready);
endinterface

interface sia_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

[hdl/sia_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sia_scan.sv]
// Match unit: compares each entry read during a scan against the key and
// remembers the matching slot and the lowest free slot. Uses sia_pkg.
`timescale 1ns / 1ps

module sia_scan
    import sia_pkg::*;
#(
    parameter int AW = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               chk_valid,
    input  logic [AW-1:0]      chk_addr,
    input  logic [ENTRY_W-1:0] rd_data,
    input  logic [31:0]        key,
    output scan_flags_t        flags,
    output logic [AW-1:0]      hit_slot,
    output logic [AW-1:0]      free_slot,
    output logic [31:0]        hit_value
);

    entry_t      ent;
    scan_flags_t flags_reg;
    logic        match;
    logic        take_free;
    logic [AW-1:0] hit_slot_reg;
    logic [AW-1:0] free_slot_reg;
    logic [31:0]   hit_value_reg;

    assign ent       = entry_t'(rd_data);
    assign match     = chk_valid && ent.used && (ent.index == key) && !flags_reg.hit;
    assign take_free = chk_valid && !ent.used && !flags_reg.free;

    // Track hit and first free flags over the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (start)
        begin
            flags_reg <= '0;
        end
        else
        begin
            if (match)
            begin
                flags_reg.hit <= 1'b1;
            end
            if (take_free)
            begin
                flags_reg.free <= 1'b1;
            end
        end
    end

    // Capture slot numbers and the stored value
    always_ff @(posedge clk)
    begin
        if (match)
        begin
            hit_slot_reg  <= chk_addr;
            hit_value_reg <= ent.value;
        end
        if (take_free)
        begin
            free_slot_reg <= chk_addr;
        end
    end

    assign flags     = flags_reg;
    assign hit_slot  = hit_slot_reg;
    assign free_slot = free_slot_reg;
    assign hit_value = hit_value_reg;

    // A slot is never both a match and free in the same check
    assert property (@(posedge clk) disable iff (!rst_n) !(match && take_free))
        else $error("scan: entry both matched and free");

endmodule

[hdl/sparse_int_array_store.sv]
// Channel | dir  | payload                         | handshake
// req     | in   | action, index, operand          | valid/ready
// rsp     | out  | result_value, status            | valid/ready
//
// Each request passes through accept, one RAM read per entry through
// the single read port, the last compare and one commit. After reset
// a clearing pass writes every entry unused; req.ready stays low meanwhile.
// The response sits in an output register, so the next request is taken
// while it waits; a commit stalls only while the previous response is
// still not taken.
// Top level of the sparse integer array store; uses sia_pkg, sia_if,
// sia_ram and sia_scan.
`timescale 1ns / 1ps

module sparse_int_array_store
    import sia_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sia_req_if.sink    req,
    sia_rsp_if.source  rsp
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          chk_valid_reg;
    logic [AW-1:0] chk_addr_reg;
    logic [2:0]    act_reg;
    logic [31:0]   idx_reg;
    logic [31:0]   opnd_reg;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_value_reg;
    logic          out_status_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    scan_flags_t   flags;
    logic [AW-1:0] hit_slot;
    logic [AW-1:0] free_slot;
    logic [31:0]   hit_value;

    logic          accept;
    logic          commit_go;
    logic [31:0]   old_val;
    logic [31:0]   addend;
    logic [31:0]   sum;
    logic [31:0]   new_val;
    logic [31:0]   res_val;
    logic          store;
    logic          do_write;
    logic          fail;
    logic [AW-1:0] wr_slot;
    entry_t        wr_entry;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign commit_go = (state_reg == ST_COMMIT) && (!out_valid_reg || rsp.ready);

    // Table storage
    sia_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(cnt_reg),
        .rdata(ram_rdata)
    );

    // Compare unit shared over all entries
    sia_scan #(
        .AW(AW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .chk_valid(chk_valid_reg),
        .chk_addr (chk_addr_reg),
        .rd_data  (ram_rdata),
        .key      (idx_reg),
        .flags    (flags),
        .hit_slot (hit_slot),
        .free_slot(free_slot),
        .hit_value(hit_value)
    );

    // Compute the new value through the single adder
    assign old_val = flags.hit ? hit_value : 32'd0;
    assign addend  = (act_reg == ACT_ADD) ? opnd_reg : 32'd1;
    assign sum     = old_val + addend;

    always_comb
    begin
        new_val = sum;
        res_val = sum;
        store   = 1'b1;
        unique case (act_reg)
            ACT_READ:
            begin
                res_val = old_val;
                store   = 1'b0;
            end
            ACT_WRITE:
            begin
                new_val = opnd_reg;
                res_val = opnd_reg;
            end
            ACT_ADD, ACT_PREINC:
            begin
                res_val = sum;
            end
            ACT_POSTINC:
            begin
                res_val = old_val;
            end
            default:
            begin
                res_val = 32'd0;
                store   = 1'b0;
            end
        endcase
    end

    // Decide the table update
    always_comb
    begin
        do_write       = 1'b0;
        fail           = 1'b0;
        wr_slot        = hit_slot;
        wr_entry.used  = 1'b1;
        wr_entry.index = idx_reg;
        wr_entry.value = new_val;
        if (store)
        begin
            if (new_val == 32'd0)
            begin
                do_write      = flags.hit;
                wr_entry.used = 1'b0;
            end
            else if (flags.hit)
            begin
                do_write = 1'b1;
            end
            else if (flags.free)
            begin
                do_write = 1'b1;
                wr_slot  = free_slot;
            end
            else
            begin
                fail = 1'b1;
            end
        end
    end

    // Drive the RAM ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_SCAN:
            begin
                ram_re = 1'b1;
            end
            ST_COMMIT:
            begin
                ram_we    = commit_go && do_write;
                ram_waddr = wr_slot;
                ram_wdata = wr_entry;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold output until taken; load it on commit
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_valid_reg <= (state_reg == ST_SCAN);
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_addr_reg <= cnt_reg;
        if (accept)
        begin
            act_reg  <= req.action;
            idx_reg  <= req.index;
            opnd_reg <= req.operand;
        end
        if (commit_go)
        begin
            out_value_reg  <= fail ? 32'd0 : res_val;
            out_status_reg <= fail ? STAT_FULL : STAT_DONE;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;

    // An accepted request always starts a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a scan");

    // A commit always presents a response next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        commit_go |=> out_valid_reg)
        else $error("commit did not load the response");

    // A present entry can never cause a full rejection
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMMIT) && flags.hit) |-> !fail)
        else $error("rejection despite matching entry");

    // RAM is written only while clearing or committing
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_COMMIT)))
        else $error("unexpected RAM write");

    // Compare results arrive only in the cycle after a scan read
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("compare without preceding read");

endmodule

[bench/testbench.sv]
// Self-checking bench for sparse_int_array_store: directed and random requests
// checked against a mirror of the index/value table. Uses sia_pkg and sia_if.
`timescale 1ns / 1ps

module testbench
    import sia_pkg::*;
();

    localparam int SLOTS        = 16;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;
    localparam int TAIL_CYCLES  = SLOTS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 12_000_000;

    // Codes above post-increment are unused and must leave the table alone
    localparam logic [2:0] ACT_MAX = 3'd7;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [31:0] value;
        logic               status;
    } outcome_t;

    typedef struct {
        logic [2:0]         action;
        logic signed [31:0] index;
        logic signed [31:0] operand;
    } request_t;

    logic clk = 1'b0;
    logic rst_n;

    sia_req_if req_ch ();
    sia_rsp_if rsp_ch ();

    sparse_int_array_store #(
        .ENTRIES(SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the table
    logic        slot_used  [SLOTS];
    logic [31:0] slot_index [SLOTS];
    logic [31:0] slot_value [SLOTS];

    outcome_t           expected_q [$];
    logic signed [31:0] index_pool [$];

    int error_count   = 0;
    int checked_count = 0;
    int full_count    = 0;
    int action_count [8] = '{default: 0};

    bit sender_gaps_on     = 1'b0;
    bit receiver_stalls_on = 1'b0;
    int hold_cycles        = 0;

    // Clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Apply one request to the mirror and return the response it must produce
    function automatic outcome_t apply_request(input logic [2:0] action,
                                               input logic [31:0] index,
                                               input logic [31:0] operand);
        outcome_t    res;
        int          hit;
        int          vacant;
        logic [31:0] prior;
        logic [31:0] updated;
        bit          stores;

        hit    = -1;
        vacant = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_index[i] == index && hit < 0)
                hit = i;
            if (!slot_used[i] && vacant < 0)
                vacant = i;
        end
        prior      = (hit >= 0) ? slot_value[hit] : '0;
        updated    = '0;
        stores     = 1'b1;
        res.status = STAT_DONE;

        case (action)
            ACT_READ:
            begin
                res.value = prior;
                stores    = 1'b0;
            end
            ACT_WRITE:
            begin
                updated   = operand;
                res.value = operand;
            end
            ACT_ADD:
            begin
                updated   = prior + operand;
                res.value = updated;
            end
            ACT_PREINC:
            begin
                updated   = prior + 32'd1;
                res.value = updated;
            end
            ACT_POSTINC:
            begin
                updated   = prior + 32'd1;
                res.value = prior;
            end
            default:
            begin
                res.value = '0;
                stores    = 1'b0;
            end
        endcase

        // Zero frees the entry; a new nonzero value takes the lowest free slot
        if (stores)
        begin
            if (updated == '0)
            begin
                if (hit >= 0)
                    slot_used[hit] = 1'b0;
            end
            else if (hit >= 0)
                slot_value[hit] = updated;
            else if (vacant >= 0)
            begin
                slot_used[vacant]  = 1'b1;
                slot_index[vacant] = index;
                slot_value[vacant] = updated;
            end
            else
            begin
                res.value  = '0;
                res.status = STAT_FULL;
                full_count++;
            end
        end
        return res;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Rebuild the set of indices that random traffic works on
    function automatic void fill_pool(input int n);
        index_pool.delete();
        index_pool.push_back(INT_MIN);
        index_pool.push_back(INT_MAX);
        index_pool.push_back(32'sd0);
        index_pool.push_back(-32'sd1);
        repeat (n - 4)
        begin
            if ($urandom_range(0, 1) == 0)
                index_pool.push_back($urandom_range(0, 63) - 32);
            else
                index_pool.push_back($urandom);
        end
    endfunction

    // Draw one request; crowded traffic leans toward actions that need entries
    function automatic request_t random_request(input bit crowded);
        request_t    item;
        int          r;
        logic [31:0] current;

        r = $urandom_range(0, 99);
        if (r < (crowded ? 10 : 20))
            item.action = ACT_READ;
        else if (r < (crowded ? 50 : 40))
            item.action = ACT_WRITE;
        else if (r < (crowded ? 65 : 60))
            item.action = ACT_ADD;
        else if (r < (crowded ? 80 : 75))
            item.action = ACT_PREINC;
        else if (r < (crowded ? 95 : 92))
            item.action = ACT_POSTINC;
        else
            item.action = 3'($urandom_range(ACT_POSTINC + 1, ACT_MAX));

        if ($urandom_range(0, 9) == 0)
            item.index = $urandom;
        else
            item.index = index_pool[$urandom_range(0, index_pool.size() - 1)];

        current = '0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_index[i] == item.index)
                current = slot_value[i];

        // Negating the stored value lets an add land on zero and free the entry
        r = $urandom_range(0, 99);
        if (r < 12)
            item.operand = '0;
        else if (r < 27)
            item.operand = -current;
        else if (r < 35)
        begin
            case ($urandom_range(0, 3))
                0:       item.operand = INT_MIN;
                1:       item.operand = INT_MAX;
                2:       item.operand = -32'sd1;
                default: item.operand = 32'sd1;
            endcase
        end
        else if (r < 60)
            item.operand = $urandom_range(0, 20) - 10;
        else
            item.operand = $urandom;
        return item;
    endfunction

    // Offer one request from a falling edge and hold it until accepted
    task automatic send_request(input logic [2:0] action,
                                input logic signed [31:0] index,
                                input logic signed [31:0] operand);
        int       gap;
        outcome_t predicted;

        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.action  = action;
        req_ch.index   = index;
        req_ch.operand = operand;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = apply_request(action, index, operand);
        expected_q.push_back(predicted);
        action_count[action]++;
        @(negedge clk);
    endtask

    task automatic send_random(input bit crowded);
        request_t item;

        item = random_request(crowded);
        send_request(item.action, item.index, item.operand);
    endtask

    // Drop valid and wait until every outstanding response has come back
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Each action at the field extremes, on an empty table
    task automatic test_basic_actions();
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        send_request(ACT_READ, 32'sd0, INT_MAX);
        send_request(ACT_WRITE, INT_MAX, INT_MIN);
        send_request(ACT_ADD, INT_MAX, -32'sd1);
        send_request(ACT_POSTINC, INT_MAX, 32'sd0);
        send_request(ACT_PREINC, INT_MIN, -32'sd1);
        // add of zero to an absent index needs no entry
        send_request(ACT_ADD, -32'sd1, 32'sd0);
        send_request(ACT_WRITE, 32'sd7, 32'sd0);
        // increment from minus one frees the entry
        send_request(ACT_WRITE, 32'sd8, -32'sd1);
        send_request(ACT_PREINC, 32'sd8, INT_MAX);
        send_request(ACT_READ, 32'sd8, 32'sd0);
        send_request(ACT_POSTINC, 32'sd9, INT_MIN);
        // write of zero to a held index frees it
        send_request(ACT_WRITE, INT_MIN, 32'sd0);
        for (int a = ACT_POSTINC + 1; a <= ACT_MAX; a++)
            send_request(3'(a), INT_MAX, $urandom);
        wait_drained();
    endtask

    // Fill the table, then probe rejection and slot reuse
    task automatic test_table_full();
        for (int i = 0; i < SLOTS; i++)
            send_request(ACT_WRITE, 1000 + i, i + 1);
        send_request(ACT_PREINC, 32'sd5000, 32'sd0);
        send_request(ACT_ADD, 32'sd5000, 32'sd0);
        send_request(ACT_WRITE, 32'sd5000, 32'sd0);
        send_request(ACT_READ, 32'sd5000, 32'sd0);
        send_request(ACT_POSTINC, 32'sd5001, 32'sd0);
        send_request(ACT_ADD, 32'sd1000, -32'sd1);
        send_request(ACT_WRITE, 32'sd5000, INT_MAX);
        send_request(ACT_READ, 32'sd5000, 32'sd0);
        wait_drained();
    endtask

    // Random traffic with idling on both sides and periodic full drains
    task automatic test_mixed_traffic(input int count);
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                fill_pool($urandom_range(6, 30));
            if (i % 150 == 149)
                wait_drained();
            send_random(1'b0);
        end
        wait_drained();
    endtask

    // Full rate on both sides
    task automatic test_back_to_back(input int count);
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        fill_pool(20);
        repeat (count) send_random(1'b0);
        wait_drained();
    endtask

    // Hold responses off for a long stretch while requests keep coming
    task automatic test_backpressure(input int count);
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        fill_pool(12);
        @(posedge clk);
        hold_cycles = HOLD_CYCLES;
        @(negedge clk);
        repeat (count) send_random(1'b0);
        wait_drained();
    endtask

    // Many distinct indices keep the table full most of the time
    task automatic test_crowded_table(input int count);
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        fill_pool(40);
        repeat (count) send_random(1'b1);
        wait_drained();
    endtask

    // Response ready: long hold-off first, then random stalls when enabled
    initial
    begin : response_sink
        int stall_left;

        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_cycles--;
            end
            else if (receiver_stalls_on && stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                if (receiver_stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin : response_check
        outcome_t want;

        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: response with none pending: value %0d status %0b",
                             $realtime, rsp_ch.result_value, rsp_ch.status);
            end
            else
            begin
                want = expected_q.pop_front();
                checked_count++;
                if (rsp_ch.result_value !== want.value || rsp_ch.status !== want.status)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected value %0d status %0b, got %0d %0b",
                                 $realtime, want.value, want.status,
                                 rsp_ch.result_value, rsp_ch.status);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Reset, then the test sequence
    initial
    begin
        int unused_count;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_READ;
        req_ch.index   = '0;
        req_ch.operand = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_index[i] = '0;
            slot_value[i] = '0;
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_basic_actions();
        test_table_full();
        test_mixed_traffic(600);
        test_back_to_back(150);
        test_backpressure(24);
        test_crowded_table(250);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        unused_count = 0;
        for (int a = ACT_POSTINC + 1; a <= ACT_MAX; a++)
            unused_count += action_count[a];
        $display("Covered %0d requests (rd %0d wr %0d add %0d pre %0d post %0d other %0d)",
                 action_count.sum(), action_count[ACT_READ], action_count[ACT_WRITE],
                 action_count[ACT_ADD], action_count[ACT_PREINC], action_count[ACT_POSTINC],
                 unused_count);
        $display("Compared %0d responses, %0d rejected on a full table, %0d errors",
                 checked_count, full_count, error_count);
        if (error_count == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/sia_pkg.sv
hdl/sia_if.sv
hdl/sia_ram.sv
hdl/sia_scan.sv
hdl/sparse_int_array_store.sv
bench/testbench.sv
